// ===== rtl/core/tempo_map_table_assert.svh =====
// Assertion macros used by the tempo map RTL.
`ifndef TEMPO_MAP_TABLE_ASSERT_SVH
`define TEMPO_MAP_TABLE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TMT_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define TMT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/tmt_pkg.sv =====
// Types, codes and constants of the tempo map table.
package tmt_pkg;
   localparam int DEF_MAX_ENTRIES = 64;
   localparam int MIN_BPM         = 10;
   localparam int MAX_BPM         = 999;
   localparam int MIN_BEATS       = 1;
   localparam int MAX_BEATS       = 32;
   localparam int MAX_BEAT_UNIT   = 64;
   localparam int MS_PER_TICK     = 1250;
   localparam int Q16_SHIFT       = 16;

   localparam int TICK_W      = 31;
   localparam int BPM_W       = 10;
   localparam int NUM_W       = 6;
   localparam int DEN_W       = 7;
   localparam int ELAPSED_W   = 54;
   localparam int PROD_W      = 42;
   localparam int QUOT_W      = PROD_W + Q16_SHIFT;
   localparam int CSR_IDX_W   = 8;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_MAP_ACTIVE = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GLOBAL_TEMPO = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GLOBAL_NUM = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GLOBAL_DEN = 8'd3;

   localparam logic [BPM_W-1:0] RST_TEMPO = 10'd140;
   localparam logic [NUM_W-1:0] RST_NUM   = 6'd4;
   localparam logic [DEN_W-1:0] RST_DEN   = 7'd4;

   typedef enum logic [1:0] {
      FN_ADD    = 2'd0,
      FN_REMOVE = 2'd1,
      FN_QUERY  = 2'd2,
      FN_CLEAR  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_INVALID   = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef struct packed {
      logic [TICK_W-1:0] tick;
      logic              has_tempo;
      logic [BPM_W-1:0]  tempo;
      logic              has_sig;
      logic [NUM_W-1:0]  num;
      logic [DEN_W-1:0]  den;
   } entry_type;

   typedef struct packed {
      logic              start;
      logic [TICK_W-1:0] ticks;
      logic [BPM_W-1:0]  bpm;
   } div_req_type;
endpackage

// ===== rtl/core/tempo_map_table.sv =====
// Tempo map table: simple dual-port event memory, op sequencer and result register.
// Add/remove: scans the entries, then shifts the entries above the insert or remove point.
// Query: scans the entries and runs the one-bit-a-cycle divider once per tempo segment below
// the tick and once more for the last segment; one op in flight.
// A new item is taken while the previous result still waits in the output register.
// Reset: table empty (count zero), registers to defaults; no clearing pass.
`include "tempo_map_table_assert.svh"
module tempo_map_table #(
   parameter int MAX_ENTRIES = tmt_pkg::DEF_MAX_ENTRIES
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // tick[30:0], has_tempo[31], tempo[41:32], has_signature[42],
   // numerator[48:43], denominator[55:49]
   input  logic [55:0]                    req_tdata,
   input  logic [1:0]                     req_tuser,   // func[1:0]
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // tempo_now[9:0], numerator_now[15:10], denominator_now[22:16],
   // elapsed_time[76:23], zero fill [79:77]
   output logic [79:0]                    rsp_tdata,
   output logic [1:0]                     rsp_tuser,   // status[1:0]
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [tmt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tmt_pkg::CSR_DATA_W-1:0] csr_data
);
   import tmt_pkg::*;

   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_SRD   = 9'b000000010,
      S_SCHK  = 9'b000000100,
      S_MRD   = 9'b000001000,
      S_MWR   = 9'b000010000,
      S_PUT   = 9'b000100000,
      S_QFIN  = 9'b001000000,
      S_QWAIT = 9'b010000000,
      S_DONE  = 9'b100000000
   } state_type;

   // configuration
   logic             map_active_ff;
   logic [BPM_W-1:0] g_tempo_ff;
   logic [NUM_W-1:0] g_num_ff;
   logic [DEN_W-1:0] g_den_ff;

   state_type  state_ff, state_in;
   func_type   op_ff, op_in;
   entry_type  ev_ff, ev_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] pos_ff, pos_in;
   status_type status_ff, status_in;
   logic [BPM_W-1:0] t_ff, t_in;
   logic [NUM_W-1:0] n_ff, n_in;
   logic [DEN_W-1:0] d_ff, d_in;
   logic [ELAPSED_W-1:0] acc_ff, acc_in;
   logic [TICK_W-1:0] cursor_ff, cursor_in;
   logic [BPM_W-1:0]  bpm_ff, bpm_in;
   logic              last_ff, last_in;

   logic             rsp_valid_ff;
   logic [79:0]      rsp_data_ff;
   status_type       rsp_status_ff;
   logic             rsp_load;

   entry_type        mem [MAX_ENTRIES];
   entry_type        rd_ff;
   logic             mem_we;
   logic [IDX_W-1:0] mem_wa, mem_ra;
   entry_type        mem_wd;

   div_req_type      div_req;
   logic             div_done;
   logic [QUOT_W-1:0] quotient;

   // request fields
   func_type          r_func;
   logic [TICK_W-1:0] r_tick;
   logic              r_ht, r_hs;
   logic [BPM_W-1:0]  r_tempo;
   logic [NUM_W-1:0]  r_num;
   logic [DEN_W-1:0]  r_den;
   logic              r_valid;
   logic [BPM_W-1:0]  g_eff;
   logic [CNT_W-1:0]  idx_dec, idx_inc;
   logic [QUOT_W:0]   sum;
   entry_type         merged;
   logic              full;

   assign r_func  = func_type'(req_tuser);
   assign r_tick  = req_tdata[30:0];
   assign r_ht    = req_tdata[31];
   assign r_tempo = req_tdata[41:32];
   assign r_hs    = req_tdata[42];
   assign r_num   = req_tdata[48:43];
   assign r_den   = req_tdata[55:49];

   assign r_valid = (r_ht || r_hs)
      && (!r_ht || (r_tempo >= BPM_W'(MIN_BPM) && r_tempo <= BPM_W'(MAX_BPM)))
      && (!r_hs || (r_num >= NUM_W'(MIN_BEATS) && r_num <= NUM_W'(MAX_BEATS)
                    && r_den != '0 && r_den <= DEN_W'(MAX_BEAT_UNIT)
                    && (r_den & (r_den - 1'b1)) == '0));

   assign g_eff = (g_tempo_ff < BPM_W'(MIN_BPM)) ? BPM_W'(MIN_BPM) :
                  (g_tempo_ff > BPM_W'(MAX_BPM)) ? BPM_W'(MAX_BPM) : g_tempo_ff;

   assign idx_dec = idx_ff - 1'b1;
   assign idx_inc = idx_ff + 1'b1;
   assign full    = (count_ff >= CNT_W'(MAX_ENTRIES));
   assign sum     = (QUOT_W + 1)'(acc_ff) + (QUOT_W + 1)'(quotient);

   always_comb begin
      merged = rd_ff;
      if (ev_ff.has_tempo) begin
         merged.has_tempo = 1'b1;
         merged.tempo     = ev_ff.tempo;
      end
      if (ev_ff.has_sig) begin
         merged.has_sig = 1'b1;
         merged.num     = ev_ff.num;
         merged.den     = ev_ff.den;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      ev_in     = ev_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      pos_in    = pos_ff;
      status_in = status_ff;
      t_in      = t_ff;
      n_in      = n_ff;
      d_in      = d_ff;
      acc_in    = acc_ff;
      cursor_in = cursor_ff;
      bpm_in    = bpm_ff;
      last_in   = last_ff;
      mem_we    = 1'b0;
      mem_wa    = idx_ff[IDX_W-1:0];
      mem_wd    = ev_ff;
      mem_ra    = idx_ff[IDX_W-1:0];
      div_req   = '0;
      rsp_load  = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in        = r_func;
               ev_in.tick      = r_tick;
               ev_in.has_tempo = r_ht;
               ev_in.tempo     = r_ht ? r_tempo : '0;
               ev_in.has_sig   = r_hs;
               ev_in.num       = r_hs ? r_num : '0;
               ev_in.den       = r_hs ? r_den : '0;
               idx_in    = '0;
               status_in = ST_OK;
               t_in      = '0;
               n_in      = '0;
               d_in      = '0;
               acc_in    = '0;
               cursor_in = '0;
               bpm_in    = g_eff;
               unique case (r_func)
                  FN_ADD: begin
                     if (!r_valid) begin
                        status_in = ST_INVALID;
                        state_in  = S_DONE;
                     end else begin
                        state_in = S_SRD;
                     end
                  end
                  FN_REMOVE: state_in = S_SRD;
                  FN_CLEAR: begin
                     count_in = '0;
                     state_in = S_DONE;
                  end
                  FN_QUERY: begin
                     t_in = g_eff;
                     n_in = g_num_ff;
                     d_in = g_den_ff;
                     state_in = (!map_active_ff || count_ff == '0) ? S_QFIN : S_SRD;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_SRD: begin
            if (idx_ff == count_ff) begin
               unique case (op_ff)
                  FN_QUERY: state_in = S_QFIN;
                  FN_ADD: begin
                     if (full) begin
                        status_in = ST_FULL;
                        state_in  = S_DONE;
                     end else begin
                        pos_in   = idx_ff;
                        state_in = S_MRD;
                     end
                  end
                  default: begin
                     status_in = ST_NOT_FOUND;
                     state_in  = S_DONE;
                  end
               endcase
            end else begin
               state_in = S_SCHK;
            end
         end
         S_SCHK: begin
            if (op_ff == FN_QUERY) begin
               if (rd_ff.tick > ev_ff.tick) begin
                  state_in = S_QFIN;
               end else begin
                  if (rd_ff.has_tempo) t_in = rd_ff.tempo;
                  if (rd_ff.has_sig) begin
                     n_in = rd_ff.num;
                     d_in = rd_ff.den;
                  end
                  idx_in = idx_inc;
                  if (rd_ff.tick < ev_ff.tick && rd_ff.has_tempo) begin
                     // segment up to this tempo change, at the tempo before it
                     div_req.start = 1'b1;
                     div_req.ticks = rd_ff.tick - cursor_ff;
                     div_req.bpm   = bpm_ff;
                     cursor_in     = rd_ff.tick;
                     bpm_in        = rd_ff.tempo;
                     last_in       = 1'b0;
                     state_in      = S_QWAIT;
                  end else begin
                     state_in = S_SRD;
                  end
               end
            end else if (rd_ff.tick >= ev_ff.tick) begin
               if (rd_ff.tick == ev_ff.tick) begin
                  if (op_ff == FN_ADD) begin
                     mem_we   = 1'b1;
                     mem_wd   = merged;
                     state_in = S_DONE;
                  end else begin
                     state_in = S_MRD;
                  end
               end else if (op_ff == FN_ADD) begin
                  if (full) begin
                     status_in = ST_FULL;
                     state_in  = S_DONE;
                  end else begin
                     pos_in   = idx_ff;
                     idx_in   = count_ff;
                     state_in = S_MRD;
                  end
               end else begin
                  status_in = ST_NOT_FOUND;
                  state_in  = S_DONE;
               end
            end else begin
               idx_in   = idx_inc;
               state_in = S_SRD;
            end
         end
         S_MRD: begin
            // insert moves entries up from the top, remove moves them down
            if (op_ff == FN_ADD) begin
               if (idx_ff == pos_ff) begin
                  state_in = S_PUT;
               end else begin
                  mem_ra   = idx_dec[IDX_W-1:0];
                  state_in = S_MWR;
               end
            end else if (idx_inc == count_ff) begin
               count_in = count_ff - 1'b1;
               state_in = S_DONE;
            end else begin
               mem_ra   = idx_inc[IDX_W-1:0];
               state_in = S_MWR;
            end
         end
         S_MWR: begin
            mem_we   = 1'b1;
            mem_wd   = rd_ff;
            idx_in   = (op_ff == FN_ADD) ? idx_dec : idx_inc;
            state_in = S_MRD;
         end
         S_PUT: begin
            mem_we   = 1'b1;
            mem_wa   = pos_ff[IDX_W-1:0];
            count_in = count_ff + 1'b1;
            state_in = S_DONE;
         end
         S_QFIN: begin
            div_req.start = 1'b1;
            div_req.ticks = ev_ff.tick - cursor_ff;
            div_req.bpm   = bpm_ff;
            last_in       = 1'b1;
            state_in      = S_QWAIT;
         end
         S_QWAIT: begin
            if (div_done) begin
               acc_in   = (sum > (QUOT_W + 1)'(ELAPSED_MAX)) ? ELAPSED_MAX
                                                            : sum[ELAPSED_W-1:0];
               state_in = last_ff ? S_DONE : S_SRD;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         map_active_ff <= 1'b0;
         g_tempo_ff    <= RST_TEMPO;
         g_num_ff      <= RST_NUM;
         g_den_ff      <= RST_DEN;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid) begin
            case (csr_index)
               CSR_MAP_ACTIVE:   map_active_ff <= csr_data[0];
               CSR_GLOBAL_TEMPO: g_tempo_ff    <= csr_data[BPM_W-1:0];
               CSR_GLOBAL_NUM:   g_num_ff      <= csr_data[NUM_W-1:0];
               CSR_GLOBAL_DEN:   g_den_ff      <= csr_data[DEN_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      ev_ff     <= ev_in;
      idx_ff    <= idx_in;
      pos_ff    <= pos_in;
      status_ff <= status_in;
      t_ff      <= t_in;
      n_ff      <= n_in;
      d_ff      <= d_in;
      acc_ff    <= acc_in;
      cursor_ff <= cursor_in;
      bpm_ff    <= bpm_in;
      last_ff   <= last_in;
      if (rsp_load) begin
         rsp_data_ff   <= {3'b000, acc_ff, d_ff, n_ff, t_ff};
         rsp_status_ff <= status_ff;
      end
   end

   // event memory; a read that meets a write of the same entry returns old
   // data and is never used
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      rd_ff <= mem[mem_ra];
   end

   tmt_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .div_done (div_done),
      .quotient (quotient)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

   `TMT_ASSERT_IMPL(a_count_bound, 1'b1, count_ff <= CNT_W'(MAX_ENTRIES), "event count over capacity")
   `TMT_ASSERT_NEXT(a_clear_empties, req_tvalid && req_tready && req_tuser == FN_CLEAR, count_ff == '0, "clear left entries")
   `TMT_ASSERT_IMPL(a_div_done_wait, div_done, state_ff == S_QWAIT, "divider finished while not awaited")
   `TMT_ASSERT_IMPL(a_write_states, mem_we, state_ff == S_SCHK || state_ff == S_MWR || state_ff == S_PUT, "table written outside an edit step")
endmodule

// ===== rtl/core/tmt_div.sv =====
// Bit-serial segment time unit: floor(ticks * 1250 * 2^16 / bpm).
module tmt_div (
   input  logic                       clock,
   input  logic                       reset,
   input  tmt_pkg::div_req_type       div_req,
   output logic                       div_done,
   output logic [tmt_pkg::QUOT_W-1:0] quotient
);
   import tmt_pkg::*;

   localparam int CNT_W = $clog2(QUOT_W + 1);

   logic              load_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              done_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [BPM_W-1:0]  bpm_ff;
   logic [QUOT_W-1:0] n_ff;
   logic [BPM_W-1:0]  rem_ff;
   logic [BPM_W:0]    trial;
   logic              qbit;
   logic [BPM_W:0]    diff;

   assign trial = {rem_ff, n_ff[QUOT_W-1]};
   assign qbit  = (trial >= {1'b0, bpm_ff});
   assign diff  = trial - {1'b0, bpm_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         load_ff <= 1'b0;
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         load_ff <= div_req.start;
         done_ff <= 1'b0;
         if (load_ff) begin
            cnt_ff <= CNT_W'(QUOT_W);
         end else if (cnt_ff != '0) begin
            cnt_ff  <= cnt_ff - 1'b1;
            done_ff <= (cnt_ff == CNT_W'(1));
         end
      end
   end

   // dividend first goes through one multiply stage, then one quotient bit a cycle
   always_ff @(posedge clock) begin
      if (div_req.start) begin
         prod_ff <= PROD_W'(div_req.ticks) * PROD_W'(MS_PER_TICK);
         bpm_ff  <= (div_req.bpm == '0) ? BPM_W'(1) : div_req.bpm;
      end
      if (load_ff) begin
         n_ff   <= {prod_ff, {Q16_SHIFT{1'b0}}};
         rem_ff <= '0;
      end else if (cnt_ff != '0) begin
         n_ff   <= {n_ff[QUOT_W-2:0], qbit};
         rem_ff <= qbit ? diff[BPM_W-1:0] : trial[BPM_W-1:0];
      end
   end

   assign div_done = done_ff;
   assign quotient = n_ff;
endmodule

// ===== tb/sv/tempo_map_checker.sv =====
// Checker for the tempo map table: predicts every response and compares it.
`timescale 1ns / 100ps
module tempo_map_checker
   import tmt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [55:0]           req_tdata,
   input  logic [1:0]            req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [79:0]           rsp_tdata,
   input  logic [1:0]            rsp_tuser,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int                    errors,
   output int                    pending
);
   localparam longint unsigned ELAPSED_MAX = (64'd1 << ELAPSED_W) - 1;

   typedef struct {
      status_type       st;
      logic [BPM_W-1:0] tempo;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
      logic [53:0]      elapsed;
   } answer_type;

   entry_type        tempo_map [DEF_MAX_ENTRIES];
   int               map_count;
   logic             map_on;
   logic [BPM_W-1:0] dflt_tempo;
   logic [NUM_W-1:0] dflt_num;
   logic [DEN_W-1:0] dflt_den;
   answer_type       answers_due [$];

   function automatic longint unsigned segment_ms(longint unsigned ticks, int bpm);
      return (ticks * MS_PER_TICK * 65536) / bpm;
   endfunction

   function automatic longint unsigned add_sat(longint unsigned a, longint unsigned b);
      longint unsigned s;
      s = a + b;
      return (s > ELAPSED_MAX) ? ELAPSED_MAX : s;
   endfunction

   function automatic answer_type run_op(func_type fn, logic [55:0] d);
      answer_type       r;
      logic [30:0]      tk;
      logic             ht, hs;
      logic [9:0]       tp;
      logic [5:0]       nm;
      logic [6:0]       dn;
      bit               ok;
      int               at, pos, g, bpm;
      longint unsigned  el, cursor;
      tk = d[30:0]; ht = d[31]; tp = d[41:32]; hs = d[42]; nm = d[48:43]; dn = d[55:49];
      r.st = ST_OK; r.tempo = '0; r.num = '0; r.den = '0; r.elapsed = '0;
      at = 0;
      while (at < map_count && tempo_map[at].tick != tk) at++;
      case (fn)
         FN_ADD: begin
            ok = ht || hs;
            if (ht && (tp < MIN_BPM || tp > MAX_BPM)) ok = 0;
            if (hs && (nm < MIN_BEATS || nm > MAX_BEATS || dn == 0 || dn > MAX_BEAT_UNIT
                       || (dn & (dn - 7'd1)) != 0)) ok = 0;
            if (!ok) begin
               r.st = ST_INVALID;
            end else if (at < map_count) begin
               if (ht) begin
                  tempo_map[at].has_tempo = 1; tempo_map[at].tempo = tp;
               end
               if (hs) begin
                  tempo_map[at].has_sig = 1; tempo_map[at].num = nm; tempo_map[at].den = dn;
               end
            end else if (map_count >= DEF_MAX_ENTRIES) begin
               r.st = ST_FULL;
            end else begin
               pos = 0;
               while (pos < map_count && tempo_map[pos].tick < tk) pos++;
               for (int i = map_count; i > pos; i--) tempo_map[i] = tempo_map[i-1];
               tempo_map[pos].tick = tk;
               tempo_map[pos].has_tempo = ht;
               tempo_map[pos].tempo = ht ? tp : '0;
               tempo_map[pos].has_sig = hs;
               tempo_map[pos].num = hs ? nm : '0;
               tempo_map[pos].den = hs ? dn : '0;
               map_count++;
            end
         end
         FN_REMOVE: begin
            if (at >= map_count) begin
               r.st = ST_NOT_FOUND;
            end else begin
               for (int i = at; i + 1 < map_count; i++) tempo_map[i] = tempo_map[i+1];
               map_count--;
            end
         end
         FN_CLEAR: map_count = 0;
         default: begin
            g = (dflt_tempo < MIN_BPM) ? MIN_BPM : (dflt_tempo > MAX_BPM) ? MAX_BPM : dflt_tempo;
            r.tempo = g; r.num = dflt_num; r.den = dflt_den;
            if (!map_on || map_count == 0) begin
               el = add_sat(0, segment_ms(tk, g));
            end else begin
               el = 0; cursor = 0; bpm = g;
               for (int i = 0; i < map_count && tempo_map[i].tick <= tk; i++) begin
                  if (tempo_map[i].has_tempo) r.tempo = tempo_map[i].tempo;
                  if (tempo_map[i].has_sig) begin
                     r.num = tempo_map[i].num; r.den = tempo_map[i].den;
                  end
               end
               // entries at the query tick itself add no segment
               for (int i = 0; i < map_count && tempo_map[i].tick < tk; i++) begin
                  if (tempo_map[i].has_tempo) begin
                     el = add_sat(el, segment_ms(tempo_map[i].tick - cursor, bpm));
                     cursor = tempo_map[i].tick;
                     bpm = tempo_map[i].tempo;
                  end
               end
               el = add_sat(el, segment_ms(tk - cursor, bpm));
            end
            r.elapsed = el[53:0];
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      answer_type a;
      if (reset) begin
         map_count = 0; map_on = 0;
         dflt_tempo = RST_TEMPO; dflt_num = RST_NUM; dflt_den = RST_DEN;
         answers_due.delete();
         errors = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MAP_ACTIVE:   map_on = csr_data[0];
               CSR_GLOBAL_TEMPO: dflt_tempo = csr_data[BPM_W-1:0];
               CSR_GLOBAL_NUM:   dflt_num = csr_data[NUM_W-1:0];
               CSR_GLOBAL_DEN:   dflt_den = csr_data[DEN_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            answers_due.push_back(run_op(func_type'(req_tuser), req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (answers_due.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected item: status %0d data %h", rsp_tuser, rsp_tdata);
            end else begin
               a = answers_due.pop_front();
               if (rsp_tuser != a.st || rsp_tdata[9:0] != a.tempo || rsp_tdata[15:10] != a.num
                   || rsp_tdata[22:16] != a.den || rsp_tdata[76:23] != a.elapsed
                   || rsp_tdata[79:77] != 3'd0) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch: exp st %0d bpm %0d sig %0d/%0d el %0d, got st %0d bpm %0d sig %0d/%0d el %0d",
                              a.st, a.tempo, a.num, a.den, a.elapsed, rsp_tuser, rsp_tdata[9:0],
                              rsp_tdata[15:10], rsp_tdata[22:16], rsp_tdata[76:23]);
               end
            end
         end
      end
      pending = answers_due.size();
   end
endmodule

// ===== tb/sv/tb.sv =====
// Testbench top: clock, reset, stimulus, response pacing and verdict.
`timescale 1ns / 100ps
module tb;
   import tmt_pkg::*;

   localparam int STALL_LIMIT = 20000;

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  req_tvalid = 0;
   logic                  req_tready;
   logic [55:0]           req_tdata = '0;
   logic [1:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 0;
   logic [79:0]           rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  csr_valid = 0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;
   int                    errors, pending;
   int                    idle_cycles = 0;
   bit                    no_gaps = 0;
   int unsigned           used_ticks [$];

   tempo_map_table u_top (.*);
   tempo_map_checker u_chk (.*);

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic int draw_gap();
      return no_gaps ? 0 : $urandom_range(0, 7);
   endfunction

   // response side: random backpressure plus one long hold-off
   initial begin
      int taken;
      int g;
      taken = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         g = draw_gap();
         if (taken == 120) g = 300;
         if (g > 0) begin
            rsp_tready <= 0;
            repeat (g) @(negedge clock);
         end
         rsp_tready <= 1;
         do @(posedge clock); while (!rsp_tvalid);
         taken++;
         @(negedge clock);
      end
   end

   // called at a falling edge; returns at a falling edge with valid still high
   task automatic send_op(func_type fn, logic [30:0] tk, logic ht = 0, logic [9:0] tp = 0,
                          logic hs = 0, logic [5:0] nm = 0, logic [6:0] dn = 0);
      int g;
      g = draw_gap();
      if (g > 0) begin
         req_tvalid <= 0;
         repeat (g) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= fn;
      req_tdata  <= {dn, nm, hs, tp, ht, tk};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      if (fn == FN_ADD && used_ticks.size() < 40) used_ticks.push_back(tk);
   endtask

   // drops valid again before it returns
   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 0;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_tvalid <= 0;
      do @(negedge clock); while (pending != 0);
   endtask

   task automatic set_globals(bit act, int bpm, int nm, int dn);
      csr_write(CSR_MAP_ACTIVE, act);
      csr_write(CSR_GLOBAL_TEMPO, bpm);
      csr_write(CSR_GLOBAL_NUM, nm);
      csr_write(CSR_GLOBAL_DEN, dn);
   endtask

   function automatic logic [30:0] pick_tick();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45 && used_ticks.size() > 0) return used_ticks[$urandom_range(0, used_ticks.size()-1)];
      if (r < 85) return $urandom_range(0, 20000);
      return $urandom;
   endfunction

   task automatic random_op();
      int r;
      logic [9:0] tp;
      logic [5:0] nm;
      logic [6:0] dn;
      logic ht, hs;
      r = $urandom_range(0, 99);
      tp = ($urandom_range(0, 9) < 8) ? $urandom_range(MIN_BPM, MAX_BPM) : $urandom;
      nm = ($urandom_range(0, 9) < 8) ? $urandom_range(MIN_BEATS, MAX_BEATS) : $urandom;
      dn = ($urandom_range(0, 9) < 8) ? (7'd1 << $urandom_range(0, 6)) : $urandom;
      ht = $urandom_range(0, 3) != 0;
      hs = $urandom_range(0, 2) == 0;
      if ($urandom_range(0, 19) == 0) begin
         ht = 0; hs = 0;
      end
      if (r < 47)      send_op(FN_ADD, pick_tick(), ht, tp, hs, nm, dn);
      else if (r < 80) send_op(FN_QUERY, pick_tick(), $urandom, $urandom, $urandom, $urandom,
                               $urandom);
      else if (r < 97) send_op(FN_REMOVE, pick_tick(), $urandom, $urandom, $urandom, $urandom,
                               $urandom);
      else begin
         send_op(FN_CLEAR, pick_tick());
         used_ticks.delete();
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // directed: default globals with the map off, then every add check
      send_op(FN_QUERY, 0);
      send_op(FN_QUERY, 31'h7fffffff);
      wait_idle();
      csr_write(CSR_MAP_ACTIVE, 1);
      send_op(FN_QUERY, 500);
      send_op(FN_ADD, 100, 1, 10, 0, 0, 0);
      send_op(FN_ADD, 100, 0, 10'h3ff, 1, 32, 64);
      send_op(FN_ADD, 0, 1, 999, 0, 0, 0);
      send_op(FN_ADD, 200, 0, 0, 0, 0, 0);
      send_op(FN_ADD, 200, 1, 9, 0, 0, 0);
      send_op(FN_ADD, 200, 1, 1000, 0, 0, 0);
      send_op(FN_ADD, 200, 0, 0, 1, 0, 4);
      send_op(FN_ADD, 200, 0, 0, 1, 33, 4);
      send_op(FN_ADD, 200, 0, 0, 1, 3, 0);
      send_op(FN_ADD, 200, 0, 0, 1, 3, 3);
      send_op(FN_ADD, 200, 0, 0, 1, 3, 127);
      send_op(FN_ADD, 300, 0, 0, 1, 1, 1);
      send_op(FN_REMOVE, 250);
      send_op(FN_QUERY, 100);
      send_op(FN_QUERY, 50);
      send_op(FN_QUERY, 300);
      send_op(FN_QUERY, 31'h7fffffff);
      send_op(FN_REMOVE, 100);
      send_op(FN_CLEAR, 0);
      send_op(FN_QUERY, 100);
      used_ticks.delete();
      wait_idle();

      for (int ph = 0; ph < 8; ph++) begin
         no_gaps = (ph % 3 == 2);
         case (ph)
            0: set_globals(1, MIN_BPM, MIN_BEATS, 1);
            1: set_globals(1, MAX_BPM, MAX_BEATS, MAX_BEAT_UNIT);
            2: set_globals(0, 140, 4, 4);
            3: set_globals(1, 0, 0, 0);
            4: set_globals(1, 1023, 63, 127);
            default: set_globals($urandom_range(0, 3) != 0, $urandom_range(0, 65535),
                                 $urandom_range(0, 65535), $urandom_range(0, 65535));
         endcase
         if (ph == 1) begin
            // fill the table, overflow it, then merge into a full table
            send_op(FN_CLEAR, 0);
            used_ticks.delete();
            for (int k = 0; k < DEF_MAX_ENTRIES; k++)
               send_op(FN_ADD, k * 100 + $urandom_range(0, 49), $urandom,
                       $urandom_range(MIN_BPM, MAX_BPM), 1,
                       $urandom_range(MIN_BEATS, MAX_BEATS), 7'd1 << $urandom_range(0, 6));
            send_op(FN_ADD, 50000, 1, 120, 0, 0, 0);
            send_op(FN_ADD, used_ticks[3], 1, 60, 1, 7, 8);
            send_op(FN_QUERY, 31'h7fffffff);
            send_op(FN_QUERY, used_ticks[20]);
            send_op(FN_REMOVE, used_ticks[5]);
         end
         repeat (85) random_op();
         wait_idle();
      end

      repeat (100) @(posedge clock);
      if (errors == 0 && pending == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/tmt_pkg.sv
rtl/core/tmt_div.sv
rtl/core/tempo_map_table.sv
tb/sv/tempo_map_checker.sv
tb/sv/tb.sv
